// ----- rtl/xtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtt_pkg
// shared types and constants of the xml tag tokenizer
// ----------------------------------------------------------------------------
package xtt_pkg;

  localparam int unsigned XTT_MAX_MARKS = 255;

  // byte classes
  localparam logic [3:0] CLS_OTHER  = 4'd0;
  localparam logic [3:0] CLS_LT     = 4'd1;
  localparam logic [3:0] CLS_GT     = 4'd2;
  localparam logic [3:0] CLS_SLASH  = 4'd3;
  localparam logic [3:0] CLS_SPACE  = 4'd4;
  localparam logic [3:0] CLS_EQ     = 4'd5;
  localparam logic [3:0] CLS_APOS   = 4'd6;
  localparam logic [3:0] CLS_QUOT   = 4'd7;
  localparam logic [3:0] CLS_AMP    = 4'd8;
  localparam logic [3:0] CLS_LETTER = 4'd9;
  localparam logic [3:0] CLS_DIGIT  = 4'd10;
  localparam logic [3:0] CLS_COLON  = 4'd11;
  localparam logic [3:0] CLS_NAME   = 4'd12;

  // token kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    ST_TEXT       = 4'd0,
    ST_LT         = 4'd1,
    ST_ELEM_NAME  = 4'd2,
    ST_ATTR_SP    = 4'd3,
    ST_ATTR_NAME  = 4'd4,
    ST_ATTR_EQ_SP = 4'd5,
    ST_VALUE_WAIT = 4'd6,
    ST_DQUOTE     = 4'd7,
    ST_SQUOTE     = 4'd8,
    ST_SLASH      = 4'd9,
    ST_END_OPEN   = 4'd10,
    ST_END_NAME   = 4'd11,
    ST_END_SP     = 4'd12,
    ST_ERROR      = 4'd13
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  byte_class;
    logic [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic        mark_valid;
    logic [31:0] mark_position;
    logic [7:0]  mark_index;
    logic        token_done;
    logic [1:0]  token_kind;
    logic        parse_error;
  } out_item_t;

endpackage

// ----- rtl/xtt_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtt_fsm
// tag automaton, mark counter and token type, one transition per step
// ----------------------------------------------------------------------------
module xtt_fsm
  import xtt_pkg::*;
#(
  parameter int unsigned MAX_MARKS = XTT_MAX_MARKS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic [7:0] MarkCap = (MAX_MARKS > 255) ? 8'd255 : 8'(MAX_MARKS);

  parse_state_t state, state_next;
  logic [7:0]   mark_count, mark_count_next;
  logic [1:0]   token_type, token_type_next;

  logic [3:0]   cls;
  logic         count_nz;
  logic         put_mark, use_prev, done;
  logic         count_sat;
  logic [31:0]  mark_pos;

  function automatic logic starts_name(input logic [3:0] c);
    starts_name = (c == CLS_LETTER) || (c == CLS_COLON);
  endfunction

  function automatic logic in_name(input logic [3:0] c);
    in_name = (c == CLS_LETTER) || (c == CLS_DIGIT) || (c == CLS_COLON) ||
              (c == CLS_NAME);
  endfunction

  // unknown classes act as other
  assign cls      = (item.byte_class > CLS_NAME) ? CLS_OTHER : item.byte_class;
  assign count_nz = (mark_count != 8'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_TEXT: begin
        if (cls == CLS_LT) state_next = ST_LT;
      end
      ST_LT: begin
        if (cls == CLS_SLASH)    state_next = ST_END_OPEN;
        else if (starts_name(cls)) state_next = ST_ELEM_NAME;
        else                     state_next = ST_ERROR;
      end
      ST_ELEM_NAME: begin
        if (cls == CLS_GT)         state_next = ST_TEXT;
        else if (cls == CLS_SLASH) state_next = ST_SLASH;
        else if (cls == CLS_SPACE) state_next = ST_ATTR_SP;
        else if (!in_name(cls))    state_next = ST_ERROR;
      end
      ST_ATTR_SP: begin
        if (cls == CLS_GT)           state_next = ST_TEXT;
        else if (cls == CLS_SLASH)   state_next = ST_SLASH;
        else if (starts_name(cls))   state_next = ST_ATTR_NAME;
        else if (cls != CLS_SPACE)   state_next = ST_ERROR;
      end
      ST_ATTR_NAME: begin
        if (cls == CLS_EQ)         state_next = ST_VALUE_WAIT;
        else if (cls == CLS_SPACE) state_next = ST_ATTR_EQ_SP;
        else if (!in_name(cls))    state_next = ST_ERROR;
      end
      ST_ATTR_EQ_SP: begin
        if (cls == CLS_EQ)         state_next = ST_VALUE_WAIT;
        else if (cls != CLS_SPACE) state_next = ST_ERROR;
      end
      ST_VALUE_WAIT: begin
        if (cls == CLS_APOS)       state_next = ST_SQUOTE;
        else if (cls == CLS_QUOT)  state_next = ST_DQUOTE;
        else if (cls != CLS_SPACE) state_next = ST_ERROR;
      end
      ST_DQUOTE: begin
        if (cls == CLS_QUOT)                         state_next = ST_ATTR_SP;
        else if (cls == CLS_LT || cls == CLS_AMP)    state_next = ST_ERROR;
      end
      ST_SQUOTE: begin
        if (cls == CLS_APOS)                         state_next = ST_ATTR_SP;
        else if (cls == CLS_LT || cls == CLS_AMP)    state_next = ST_ERROR;
      end
      ST_SLASH: begin
        state_next = (cls == CLS_GT) ? ST_TEXT : ST_ERROR;
      end
      ST_END_OPEN: begin
        state_next = starts_name(cls) ? ST_END_NAME : ST_ERROR;
      end
      ST_END_NAME: begin
        if (cls == CLS_GT)         state_next = ST_TEXT;
        else if (cls == CLS_SPACE) state_next = ST_END_SP;
        else if (!in_name(cls))    state_next = ST_ERROR;
      end
      ST_END_SP: begin
        if (cls == CLS_GT)         state_next = ST_TEXT;
        else if (cls != CLS_SPACE) state_next = ST_ERROR;
      end
      ST_ERROR: state_next = ST_ERROR;
      default:  state_next = ST_ERROR;
    endcase
  end

  // mark, completion and token type
  always_comb begin
    put_mark        = 1'b0;
    use_prev        = 1'b0;
    done            = 1'b0;
    token_type_next = token_type;
    unique case (state)
      ST_TEXT: begin
        if (cls == CLS_LT) begin
          put_mark = count_nz;
          use_prev = 1'b1;
          done     = count_nz;
        end else if (!count_nz) begin
          token_type_next = KIND_TEXT;
          put_mark        = 1'b1;
        end
      end
      ST_LT: begin
        if (cls == CLS_SLASH) begin
          token_type_next = KIND_END;
        end else if (starts_name(cls)) begin
          token_type_next = KIND_START;
          put_mark        = 1'b1;
        end
      end
      ST_ELEM_NAME, ST_END_NAME: begin
        use_prev = 1'b1;
        if (cls == CLS_GT) begin
          put_mark = count_nz;
          done     = count_nz;
        end else if (cls == CLS_SPACE ||
                     (cls == CLS_SLASH && state == ST_ELEM_NAME)) begin
          put_mark = 1'b1;
        end
      end
      ST_ATTR_SP: begin
        if (cls == CLS_GT) done = count_nz;
        else if (cls != CLS_SLASH && starts_name(cls)) put_mark = 1'b1;
      end
      ST_ATTR_NAME: begin
        use_prev = 1'b1;
        put_mark = (cls == CLS_EQ) || (cls == CLS_SPACE);
      end
      ST_VALUE_WAIT: put_mark = (cls == CLS_APOS) || (cls == CLS_QUOT);
      ST_DQUOTE:     put_mark = (cls == CLS_QUOT);
      ST_SQUOTE:     put_mark = (cls == CLS_APOS);
      ST_SLASH: begin
        token_type_next = KIND_EMPTY;
        done            = (cls == CLS_GT) && count_nz;
      end
      ST_END_OPEN:   put_mark = starts_name(cls);
      ST_END_SP:     done = (cls == CLS_GT) && count_nz;
      ST_ATTR_EQ_SP, ST_ERROR: begin
        put_mark = 1'b0;
      end
      default: put_mark = 1'b0;
    endcase
  end

  assign count_sat = (mark_count >= MarkCap);
  assign mark_pos  = use_prev ? (item.position - 32'd1) : item.position;

  always_comb begin
    if (done) begin
      mark_count_next = 8'd0;
    end else if (put_mark && !count_sat) begin
      mark_count_next = mark_count + 8'd1;
    end else begin
      mark_count_next = mark_count;
    end
  end

  always_comb begin
    result.mark_valid    = put_mark;
    result.mark_position = put_mark ? mark_pos : 32'd0;
    result.mark_index    = put_mark ? (count_sat ? MarkCap : mark_count) : 8'd0;
    result.token_done    = done;
    result.token_kind    = token_type_next;
    result.parse_error   = (state_next == ST_ERROR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_TEXT;
      mark_count <= 8'd0;
      token_type <= KIND_TEXT;
    end else if (step_en) begin
      state      <= state_next;
      mark_count <= mark_count_next;
      token_type <= token_type_next;
    end
  end

endmodule

// ----- rtl/xml_tag_tokenizer.sv -----
`timescale 1ns / 1ps
// a request is held in the input register, then stepped into the result register
// throughput: one byte per cycle while the consumer does not stall, with the
// automaton step between the input register and the result register
// reset: synchronous, clears the automaton to text state, mark count to zero,
// token type to text and both pipeline valid flags
// ----------------------------------------------------------------------------
// xml_tag_tokenizer
// streaming xml tag automaton emitting position marks per classified byte
// ----------------------------------------------------------------------------
module xml_tag_tokenizer
  import xtt_pkg::*;
#(
  parameter int unsigned MAX_MARKS = XTT_MAX_MARKS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // input register stage
  logic      s1_valid;
  in_item_t  s1_item;

  // step fires when the byte is held and the result register can take it
  logic      advance;
  out_item_t step_result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  // new request may enter whenever the input stage empties this cycle
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // automaton with its own state registers, stepped once per advance
  xtt_fsm #(
    .MAX_MARKS(MAX_MARKS)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step_en(advance),
    .item   (s1_item),
    .result (step_result)
  );

  // result register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

`ifndef SYNTHESIS
  // a completed token never comes from the error state
  a_done_not_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.token_done |-> !out_item.parse_error)
    else $error("token completion flagged with parse error");

  // without a mark the mark fields are zero
  a_mark_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.mark_valid |->
      (out_item.mark_position == 32'd0) && (out_item.mark_index == 8'd0))
    else $error("mark fields nonzero without a mark");

  // a step always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("stepped result lost");

  // an accepted request always occupies the input stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request lost");
`endif

endmodule
